// File: rtl/double_ended_queue_with_search_macros.svh
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared property forms for the deque checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Shared constants, codes and types of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic signed [31:0] data_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [2:0]         opcode_t;
    typedef logic [1:0]         status_t;

    localparam opcode_t OP_PUSH_BACK  = 3'd0;
    localparam opcode_t OP_PUSH_FRONT = 3'd1;
    localparam opcode_t OP_POP_FRONT  = 3'd2;
    localparam opcode_t OP_POP_BACK   = 3'd3;
    localparam opcode_t OP_SEARCH     = 3'd4;
    localparam opcode_t OP_CLEAR      = 3'd5;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // Per-cell control signals.
    typedef struct packed {
        logic load;         // take the request word
        logic shift_back;   // take the word of the cell in front
        logic shift_front;  // take the word of the cell behind
        logic occupied;     // cell holds a live entry
    } cell_ctrl_t;

endpackage

// File: rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One storage cell of the queue: holds a word, moves it along the chain and
// compares it against the search key.
// ----------------------------------------------------------------------------
module deq_cell (
    input  logic                aclk,
    input  deq_pkg::cell_ctrl_t ctrl,
    input  deq_pkg::data_t      load_word,
    input  deq_pkg::data_t      prev_word,
    input  deq_pkg::data_t      next_word,
    input  deq_pkg::data_t      key,
    output deq_pkg::data_t      word,
    output logic                match
);

    deq_pkg::data_t word_reg;
    deq_pkg::data_t word_next;

    always_comb begin
        if (ctrl.load) begin
            word_next = load_word;
        end else if (ctrl.shift_back) begin
            word_next = prev_word;
        end else if (ctrl.shift_front) begin
            word_next = next_word;
        end else begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign match = ctrl.occupied && (word_reg == key);

endmodule

// File: rtl/double_ended_queue_with_search.sv
// ----------------------------------------------------------------------------
// Double-ended queue with search: a row of DEPTH cells, front entry in cell 0.
// Each result is registered; throughput 1 request/cycle unless a pending result is stalled by m_ready.
// All operations, search included, complete on acceptance (parallel compare per cell).
// Reset: synchronous active-low aresetn empties the queue and the result slot.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  deq_pkg::opcode_t    s_opcode,
    input  deq_pkg::data_t      s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output deq_pkg::status_t    m_status,
    output logic                m_found,
    output deq_pkg::count_t     m_count,
    output logic                m_is_empty
);

    localparam deq_pkg::count_t FULL_COUNT = deq_pkg::CNT_W'(deq_pkg::DEPTH);

    deq_pkg::count_t  count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    deq_pkg::status_t status_reg, status_next;
    logic             found_reg, found_next;
    deq_pkg::count_t  out_count_reg;
    logic             is_empty_reg;

    deq_pkg::data_t     words   [deq_pkg::DEPTH];
    logic               hits    [deq_pkg::DEPTH];
    deq_pkg::cell_ctrl_t ctrl   [deq_pkg::DEPTH];
    logic [deq_pkg::DEPTH-1:0] match_vec;

    logic accept;
    logic is_full, is_empty_now;
    logic do_push_back, do_push_front, do_pop_front;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign is_full      = (count_reg == FULL_COUNT);
    assign is_empty_now = (count_reg == '0);

    assign do_push_back  = accept && (s_opcode == deq_pkg::OP_PUSH_BACK)  && !is_full;
    assign do_push_front = accept && (s_opcode == deq_pkg::OP_PUSH_FRONT) && !is_full;
    assign do_pop_front  = accept && (s_opcode == deq_pkg::OP_POP_FRONT)  && !is_empty_now;

    for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
        localparam deq_pkg::count_t IDX = deq_pkg::CNT_W'(i);

        always_comb begin
            ctrl[i].load        = (do_push_back && (count_reg == IDX))
                               || (do_push_front && (i == 0));
            ctrl[i].shift_back  = do_push_front && (i != 0);
            ctrl[i].shift_front = do_pop_front && (i != deq_pkg::DEPTH - 1);
            ctrl[i].occupied    = (IDX < count_reg);
        end

        deq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl[i]),
            .load_word (s_value),
            .prev_word (words[(i == 0) ? 0 : i - 1]),
            .next_word (words[(i == deq_pkg::DEPTH - 1) ? i : i + 1]),
            .key       (s_value),
            .word      (words[i]),
            .match     (hits[i])
        );

        assign match_vec[i] = hits[i];
    end

    always_comb begin
        count_next  = count_reg;
        status_next = deq_pkg::ST_OK;
        found_next  = 1'b0;
        case (s_opcode)
            deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
                if (is_full) begin
                    status_next = deq_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                if (is_empty_now) begin
                    status_next = deq_pkg::ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            deq_pkg::OP_SEARCH: begin
                found_next = |match_vec;
            end
            deq_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload: load only on an accepted request.
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            out_count_reg <= count_next;
            is_empty_reg  <= (count_next == '0);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = status_reg;
    assign m_found    = found_reg;
    assign m_count    = out_count_reg;
    assign m_is_empty = is_empty_reg;

endmodule

// File: rtl/deq_checker.sv
// ----------------------------------------------------------------------------
// Deque checker
// Port-level properties of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "double_ended_queue_with_search_macros.svh"

module deq_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             m_valid,
    input  logic             m_ready,
    input  deq_pkg::status_t m_status,
    input  logic             m_found,
    input  deq_pkg::count_t  m_count,
    input  logic             m_is_empty
);

    localparam deq_pkg::count_t FULL_COUNT = deq_pkg::CNT_W'(deq_pkg::DEPTH);

    `DEQ_ASSERT_NEXT(a_result_holds, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_found) && $stable(m_count),
        "stalled result changed")
    `DEQ_ASSERT_NEXT(a_accept_gives_result, s_valid && s_ready, m_valid,
        "accepted request gave no result")
    `DEQ_ASSERT_NOW(a_empty_flag, m_valid, m_is_empty == (m_count == '0),
        "empty flag disagrees with count")
    `DEQ_ASSERT_NOW(a_count_bound, m_valid, m_count <= FULL_COUNT, "count exceeds depth")
    `DEQ_ASSERT_NOW(a_found_ok, m_valid && m_found, m_status == deq_pkg::ST_OK,
        "found with error status")

endmodule

bind double_ended_queue_with_search deq_checker u_deq_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_status   (m_status),
    .m_found    (m_found),
    .m_count    (m_count),
    .m_is_empty (m_is_empty)
);

// File: tb/sv/double_ended_queue_with_search_test.sv
// ----------------------------------------------------------------------------
// Double-ended queue with search: self-checking testbench
// Drives push, pop, search, clear and unused opcodes through the request
// channel and checks every result against a queue-based prediction of the
// deque contents. Directed corner cases come first (empty, full, word
// extremes), then random traffic that sweeps the fill level with random
// gaps and stalls, a pass that drains every result, and a full-rate stream.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam deq_pkg::opcode_t OP_UNUSED_6 = 3'd6;
    localparam deq_pkg::opcode_t OP_UNUSED_7 = 3'd7;
    localparam int               QUIET_LIMIT = 200;
    localparam int               END_CYCLES  = 8;

    typedef struct {
        deq_pkg::status_t status;
        logic             found;
        deq_pkg::count_t  count;
        logic             is_empty;
    } deq_result_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_valid  = 1'b0;
    logic             s_ready;
    deq_pkg::opcode_t s_opcode = deq_pkg::OP_SEARCH;
    deq_pkg::data_t   s_value  = '0;
    logic             m_valid;
    logic             m_ready  = 1'b0;
    deq_pkg::status_t m_status;
    logic             m_found;
    deq_pkg::count_t  m_count;
    logic             m_is_empty;

    deq_pkg::data_t held_words[$];
    deq_result_t    pending_results[$];
    bit          idle_on    = 1'b1;
    bit          filling    = 1'b1;
    logic [4:0]  stall_left = '0;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          n_requests = 0;
    int          n_full_drops = 0;
    int          n_empty_removals = 0;
    int          n_searches = 0;
    int          n_search_hits = 0;

    double_ended_queue_with_search i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_found    (m_found),
        .m_count    (m_count),
        .m_is_empty (m_is_empty)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one request to the predicted deque and return its result.
    function automatic deq_result_t apply_request(deq_pkg::opcode_t op, deq_pkg::data_t word);
        deq_result_t r;
        r.status = deq_pkg::ST_OK;
        r.found  = 1'b0;
        case (op)
            deq_pkg::OP_PUSH_BACK: begin
                if (held_words.size() >= deq_pkg::DEPTH) r.status = deq_pkg::ST_FULL;
                else held_words.push_back(word);
            end
            deq_pkg::OP_PUSH_FRONT: begin
                if (held_words.size() >= deq_pkg::DEPTH) r.status = deq_pkg::ST_FULL;
                else held_words.push_front(word);
            end
            deq_pkg::OP_POP_FRONT: begin
                if (held_words.size() == 0) r.status = deq_pkg::ST_EMPTY;
                else void'(held_words.pop_front());
            end
            deq_pkg::OP_POP_BACK: begin
                if (held_words.size() == 0) r.status = deq_pkg::ST_EMPTY;
                else void'(held_words.pop_back());
            end
            deq_pkg::OP_SEARCH: begin
                foreach (held_words[i]) begin
                    if (held_words[i] == word) r.found = 1'b1;
                end
            end
            deq_pkg::OP_CLEAR: held_words.delete();
            default: ;
        endcase
        r.count    = deq_pkg::count_t'(held_words.size());
        r.is_empty = (held_words.size() == 0);
        return r;
    endfunction

    // Small pool for duplicates, extremes, and full-range words.
    function automatic deq_pkg::data_t pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3, 4: return deq_pkg::data_t'($urandom_range(0, 7)) - 32'sd4;
            default: return deq_pkg::data_t'($urandom);
        endcase
    endfunction

    function automatic deq_pkg::data_t pick_key();
        if (held_words.size() != 0 && $urandom_range(0, 1) == 1)
            return held_words[$urandom_range(0, held_words.size() - 1)];
        return pick_word();
    endfunction

    // Lean toward pushes while filling and pops while draining.
    function automatic deq_pkg::opcode_t pick_opcode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2) return deq_pkg::OP_CLEAR;
        if (r < 4) return $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
        if (r < 24) return deq_pkg::OP_SEARCH;
        if ((r < 79) == filling)
            return $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
        return $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
    endfunction

    // Returns at the rising edge that accepts the request.
    task automatic send_request(deq_pkg::opcode_t op, deq_pkg::data_t word);
        int unsigned gap;
        deq_result_t predicted;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= word;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(op, word);
        pending_results.push_back(predicted);
        n_requests++;
        if (predicted.status == deq_pkg::ST_FULL) n_full_drops++;
        if (predicted.status == deq_pkg::ST_EMPTY) n_empty_removals++;
        if (op == deq_pkg::OP_SEARCH) n_searches++;
        if (predicted.found) n_search_hits++;
        if (held_words.size() == deq_pkg::DEPTH) filling = 1'b0;
        if (held_words.size() == 0) filling = 1'b1;
    endtask

    task automatic send_random();
        deq_pkg::opcode_t op;
        op = pick_opcode();
        send_request(op, (op == deq_pkg::OP_SEARCH) ? pick_key() : pick_word());
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic test_empty_queue();
        send_request(deq_pkg::OP_POP_FRONT, 32'sd5);
        send_request(deq_pkg::OP_POP_BACK, -32'sd5);
        send_request(deq_pkg::OP_SEARCH, 32'sd0);
        send_request(deq_pkg::OP_CLEAR, 32'sd0);
    endtask

    task automatic test_fill_to_capacity();
        deq_pkg::data_t words[4];
        words = '{32'sh7fffffff, 32'sh80000000, 32'sh00000000, -32'sd1};
        for (int i = 0; i < deq_pkg::DEPTH; i++) begin
            send_request(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                         (i < 4) ? words[i]
                                 : deq_pkg::data_t'(32'h5a5a0000 ^ (i * 32'h01010101)));
        end
        send_request(deq_pkg::OP_PUSH_BACK, 32'sh55555555);
        send_request(deq_pkg::OP_PUSH_FRONT, 32'shaaaaaaaa);
        send_request(deq_pkg::OP_SEARCH, 32'sh80000000);
        send_request(OP_UNUSED_6, 32'sh12345678);
        send_request(OP_UNUSED_7, -32'sd1);
    endtask

    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0) filling = !filling;
            send_random();
        end
    endtask

    task automatic test_drain_pauses(int n);
        for (int i = 0; i < n; i++) begin
            send_random();
            if (i % 10 == 9) drain_results();
        end
    endtask

    task automatic test_full_rate_stream(int n);
        idle_on = 1'b0;
        for (int i = 0; i < n; i++) send_random();
    endtask

    // Result stall generator.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 5'd1;
            if (stall_left == 5'd1) m_ready <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= 5'($urandom_range(1, 16));
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        deq_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d count %0d", m_status, m_count);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_status);
                    fail_count++;
                end
                if (m_found !== exp_r.found) begin
                    $error("found: expected %0d, got %0d", exp_r.found, m_found);
                    fail_count++;
                end
                if (m_count !== exp_r.count) begin
                    $error("count: expected %0d, got %0d", exp_r.count, m_count);
                    fail_count++;
                end
                if (m_is_empty !== exp_r.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", exp_r.is_empty, m_is_empty);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("double_ended_queue_with_search_test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_queue();
        test_fill_to_capacity();
        test_random_traffic(300);
        test_drain_pauses(30);
        test_full_rate_stream(100);
        drain_results();
        repeat (END_CYCLES) @(posedge aclk);
        $display("%0d requests sent: %0d pushes dropped on full, %0d removals on empty,",
                 n_requests, n_full_drops, n_empty_removals);
        $display("%0d searches (%0d hits), under random gaps, stalls and a full-rate stream",
                 n_searches, n_search_hits);
        if (fail_count == 0) begin
            $display("double_ended_queue_with_search_test passed");
        end else begin
            $display("double_ended_queue_with_search_test failed");
        end
        $finish;
    end

endmodule
